>>> hdl/bpsv_pkg.sv
package bpsv_pkg;

  localparam int CARD_W    = 2;
  localparam int BUNCH_W   = 9;
  localparam int ADC_W     = 16;
  localparam int OFFSET_W  = 10;
  localparam int COUNT_W   = 3;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_NUM_CARDS       = 4;
  localparam int DEF_NUM_BUNCH_SLOTS = 320;
  localparam int DEF_SAMPLE_BITS     = 16;
  localparam int DEF_MAX_TURNS       = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_TIMING_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIES      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMING_BLOCK = 2'd2;

  typedef struct packed {
    logic [CARD_W-1:0]       card_index;
    logic [BUNCH_W-1:0]      bunch_index;
    logic signed [ADC_W-1:0] adc_sample;
    logic                    last_turn;
    logic                    last_sample;
  } in_beat_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] pattern_offset;
    logic [BUNCH_W-1:0]  winning_bunch;
    logic [COUNT_W-1:0]  vote_count;
  } out_beat_t;

  typedef struct packed {
    logic timing_mode;
    logic species;
    logic timing_block;
  } cfg_t;

endpackage

>>> hdl/bunch_peak_search_vote_unit.sv
// channel | dir | handshake              | beat
// in      | in  | in_valid / in_ready    | in_beat_t: card, bunch, sample, last flags
// out     | out | out_valid / out_ready  | out_beat_t: offset, bunch, count
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data bit 0
//
// One beat per cycle unless a stalled vote beat backs up. Four register stages: input, accumulate, per-card best, vote.
// A last_sample beat yields its result after the accumulate, per-card best and vote registers in turn.
// Sum-to-best and vote paths set the cycle; the turn_sum add/saturate loop closes through the turn_sum register alone.
// rst (sync) clears sums, best flags, config and all valids; no clearing pass.
// out stalls back up only through stages holding a vote beat; cfg_ready is always high.
module bunch_peak_search_vote_unit #(
  parameter int NUM_CARDS       = bpsv_pkg::DEF_NUM_CARDS,
  parameter int NUM_BUNCH_SLOTS = bpsv_pkg::DEF_NUM_BUNCH_SLOTS,
  parameter int SAMPLE_BITS     = bpsv_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_TURNS       = bpsv_pkg::DEF_MAX_TURNS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bpsv_pkg::in_beat_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bpsv_pkg::out_beat_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpsv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                           cfg_data
);
  import bpsv_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_TURNS);

  cfg_t                              cfg;
  logic                              b_valid;
  logic                              b_ready;
  logic [CARD_W-1:0]                 b_card;
  logic [BUNCH_W-1:0]                b_bunch;
  logic signed [SUM_W-1:0]           b_sum;
  logic                              b_last_turn;
  logic                              b_last_sample;
  logic                              c_valid;
  logic                              c_ready;
  logic [NUM_CARDS-1:0][BUNCH_W-1:0] c_bunch;
  logic [NUM_CARDS-1:0]              c_hit_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TIMING_MODE:  cfg.timing_mode  <= cfg_data;
        REG_SPECIES:      cfg.species      <= cfg_data;
        REG_TIMING_BLOCK: cfg.timing_block <= cfg_data;
        default: ;
      endcase
    end
  end

  bpsv_accum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_TURNS   (MAX_TURNS)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_card        (b_card),
    .b_bunch       (b_bunch),
    .b_sum         (b_sum),
    .b_last_turn   (b_last_turn),
    .b_last_sample (b_last_sample)
  );

  bpsv_best #(
    .NUM_CARDS       (NUM_CARDS),
    .NUM_BUNCH_SLOTS (NUM_BUNCH_SLOTS),
    .SUM_W           (SUM_W)
  ) u_best (
    .clk           (clk),
    .rst           (rst),
    .species       (cfg.species),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_card        (b_card),
    .b_bunch       (b_bunch),
    .b_sum         (b_sum),
    .b_last_turn   (b_last_turn),
    .b_last_sample (b_last_sample),
    .c_valid       (c_valid),
    .c_ready       (c_ready),
    .c_bunch       (c_bunch),
    .c_hit_valid   (c_hit_valid)
  );

  bpsv_vote #(
    .NUM_CARDS (NUM_CARDS)
  ) u_vote (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .c_valid     (c_valid),
    .c_ready     (c_ready),
    .c_bunch     (c_bunch),
    .c_hit_valid (c_hit_valid),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

>>> hdl/bpsv_accum.sv
module bpsv_accum #(
  parameter int SAMPLE_BITS = bpsv_pkg::DEF_SAMPLE_BITS,
  parameter int MAX_TURNS   = bpsv_pkg::DEF_MAX_TURNS,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_TURNS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpsv_pkg::in_beat_t           in_data,
  output logic                         b_valid,
  input  logic                         b_ready,
  output logic [bpsv_pkg::CARD_W-1:0]  b_card,
  output logic [bpsv_pkg::BUNCH_W-1:0] b_bunch,
  output logic signed [SUM_W-1:0]      b_sum,
  output logic                         b_last_turn,
  output logic                         b_last_sample
);
  import bpsv_pkg::*;

  localparam int     EXT_W = SUM_W + 1;
  localparam longint LIM   = (longint'(1) << (SAMPLE_BITS - 1)) * longint'(MAX_TURNS);
  localparam logic signed [EXT_W-1:0] SUM_HI = EXT_W'(LIM - 1);
  localparam logic signed [EXT_W-1:0] SUM_LO = EXT_W'(-LIM);

  logic                     a_valid;
  in_beat_t                 a;
  logic signed [SUM_W-1:0]  turn_sum;
  logic [SAMPLE_BITS-1:0]   raw;
  logic signed [EXT_W-1:0]  sample_ext;
  logic signed [EXT_W-1:0]  raw_sum;
  logic signed [EXT_W-1:0]  sat_sum;
  logic                     b_free;
  logic                     a_go;

  generate
    if (SAMPLE_BITS <= ADC_W) begin : g_narrow
      assign raw = a.adc_sample[SAMPLE_BITS-1:0];
    end else begin : g_wide
      assign raw = {{(SAMPLE_BITS - ADC_W){1'b0}}, a.adc_sample};
    end
  endgenerate

  assign sample_ext = EXT_W'($signed(raw));
  assign raw_sum    = EXT_W'(turn_sum) + sample_ext;

  always_comb begin
    if (raw_sum > SUM_HI) begin
      sat_sum = SUM_HI;
    end else if (raw_sum < SUM_LO) begin
      sat_sum = SUM_LO;
    end else begin
      sat_sum = raw_sum;
    end
  end

  assign b_free   = !b_valid || b_ready;
  assign a_go     = a_valid && b_free;
  assign in_ready = !a_valid || b_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      turn_sum <= '0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (b_free) begin
        b_valid <= a_valid;
      end
      if (a_go) begin
        turn_sum <= (a.last_turn || a.last_sample) ? '0 : SUM_W'(sat_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a <= in_data;
    end
    if (a_go) begin
      b_card        <= a.card_index;
      b_bunch       <= a.bunch_index;
      b_sum         <= SUM_W'(sat_sum);
      b_last_turn   <= a.last_turn;
      b_last_sample <= a.last_sample;
    end
  end

endmodule

>>> hdl/bpsv_best.sv
module bpsv_best #(
  parameter int NUM_CARDS       = bpsv_pkg::DEF_NUM_CARDS,
  parameter int NUM_BUNCH_SLOTS = bpsv_pkg::DEF_NUM_BUNCH_SLOTS,
  parameter int SUM_W           = bpsv_pkg::DEF_SAMPLE_BITS + $clog2(bpsv_pkg::DEF_MAX_TURNS)
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        species,
  input  logic                                        b_valid,
  output logic                                        b_ready,
  input  logic [bpsv_pkg::CARD_W-1:0]                 b_card,
  input  logic [bpsv_pkg::BUNCH_W-1:0]                b_bunch,
  input  logic signed [SUM_W-1:0]                     b_sum,
  input  logic                                        b_last_turn,
  input  logic                                        b_last_sample,
  output logic                                        c_valid,
  input  logic                                        c_ready,
  output logic [NUM_CARDS-1:0][bpsv_pkg::BUNCH_W-1:0] c_bunch,
  output logic [NUM_CARDS-1:0]                        c_hit_valid
);
  import bpsv_pkg::*;

  logic signed [SUM_W-1:0] best_sum [NUM_CARDS];
  logic [BUNCH_W-1:0]      best_bunch [NUM_CARDS];
  logic [NUM_CARDS-1:0]    best_valid;

  logic signed [SUM_W-1:0]            sum_next [NUM_CARDS];
  logic [NUM_CARDS-1:0][BUNCH_W-1:0]  bunch_next;
  logic [NUM_CARDS-1:0]               valid_next;
  logic [NUM_CARDS-1:0]               upd;
  logic                               in_range;
  logic                               b_go;

  assign in_range = (32'(b_bunch) < 32'(NUM_BUNCH_SLOTS)) && (32'(b_card) < 32'(NUM_CARDS));
  assign b_ready  = !b_last_sample || !c_valid || c_ready;
  assign b_go     = b_valid && b_ready;

  always_comb begin
    for (int c = 0; c < NUM_CARDS; c++) begin
      upd[c] = b_last_turn && in_range && (32'(b_card) == 32'(c)) &&
               (!best_valid[c] || (species ? (b_sum < best_sum[c]) : (b_sum > best_sum[c])));
      valid_next[c] = best_valid[c] | upd[c];
      bunch_next[c] = upd[c] ? b_bunch : best_bunch[c];
      sum_next[c]   = upd[c] ? b_sum : best_sum[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= '0;
      c_valid    <= 1'b0;
    end else begin
      if (!c_valid || c_ready) begin
        c_valid <= b_go && b_last_sample;
      end
      if (b_go) begin
        // vote beat starts a fresh scan
        best_valid <= b_last_sample ? '0 : valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_go) begin
      for (int c = 0; c < NUM_CARDS; c++) begin
        best_sum[c]   <= sum_next[c];
        best_bunch[c] <= bunch_next[c];
      end
      if (b_last_sample) begin
        c_bunch     <= bunch_next;
        c_hit_valid <= valid_next;
      end
    end
  end

endmodule

>>> hdl/bpsv_vote.sv
module bpsv_vote #(
  parameter int NUM_CARDS = bpsv_pkg::DEF_NUM_CARDS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  bpsv_pkg::cfg_t                              cfg,
  input  logic                                        c_valid,
  output logic                                        c_ready,
  input  logic [NUM_CARDS-1:0][bpsv_pkg::BUNCH_W-1:0] c_bunch,
  input  logic [NUM_CARDS-1:0]                        c_hit_valid,
  output logic                                        out_valid,
  input  logic                                        out_ready,
  output bpsv_pkg::out_beat_t                         out_data
);
  import bpsv_pkg::*;

  localparam int HIT_W = $clog2(NUM_CARDS + 1);

  logic [HIT_W-1:0]   hits [NUM_CARDS];
  logic [HIT_W-1:0]   top_hits;
  logic [BUNCH_W-1:0] win;
  logic               odd;
  out_beat_t          result;

  always_comb begin
    for (int a = 0; a < NUM_CARDS; a++) begin
      hits[a] = '0;
      for (int b = 0; b < NUM_CARDS; b++) begin
        if (c_hit_valid[a] && c_hit_valid[b] && (c_bunch[b] == c_bunch[a])) begin
          hits[a] = hits[a] + HIT_W'(1);
        end
      end
    end
    top_hits = '0;
    win      = '0;
    // strict compare: first card with the top count wins
    for (int a = 0; a < NUM_CARDS; a++) begin
      if (c_hit_valid[a] && (hits[a] > top_hits)) begin
        top_hits = hits[a];
        win      = c_bunch[a];
      end
    end
  end

  assign odd = cfg.timing_mode ? cfg.species : cfg.timing_block;

  always_comb begin
    result.winning_bunch  = win;
    result.vote_count     = COUNT_W'(top_hits);
    result.pattern_offset = (top_hits == '0) ? '0 : {win, odd};
  end

  assign c_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (c_ready) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && c_valid) begin
      out_data <= result;
    end
  end

endmodule

>>> hdl/bpsv_checker.sv
module bpsv_checker #(
  parameter int NUM_CARDS = bpsv_pkg::DEF_NUM_CARDS
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input bpsv_pkg::in_beat_t             in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input bpsv_pkg::out_beat_t            out_data
);
  import bpsv_pkg::*;

  // vote beats accepted but not yet delivered
  logic [2:0] pending;
  logic       ls_in;
  logic       res_out;

  assign ls_in   = in_valid && in_ready && in_data.last_sample;
  assign res_out = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(ls_in) - 3'(res_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result beat without a pending last sample");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data.vote_count) <= NUM_CARDS)
    else $error("vote count above card count");

  a_empty_vote: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vote_count == '0 |->
      out_data.pattern_offset == '0 && out_data.winning_bunch == '0)
    else $error("empty vote with nonzero bunch or offset");

  a_offset_bunch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.vote_count != '0 |->
      out_data.pattern_offset[OFFSET_W-1:1] == out_data.winning_bunch)
    else $error("offset does not match winning bunch");

endmodule

bind bunch_peak_search_vote_unit bpsv_checker #(.NUM_CARDS(NUM_CARDS)) u_bpsv_checker (.*);
